// ----- rtl/core/udiv64_pkg.sv -----
// Shared types for the pipelined unsigned divider.
// No dependencies; imported by udiv64_step, unsigned_64bit_divider and the testbench.
package udiv64_pkg;

    // Width of the operand and result ports
    localparam int FIELD_WIDTH = 64;

    typedef logic [FIELD_WIDTH-1:0] field_t;

    // Control that travels with each beat down the pipeline
    typedef struct packed {
        logic valid;
        logic dbz;
    } udiv_ctl_t;

endpackage

// ----- rtl/core/udiv64_step.sv -----
// One registered restoring-division step: resolves one quotient bit.
// Depends on udiv64_pkg for the control struct.
module udiv64_step #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  udiv64_pkg::udiv_ctl_t  ctl_in,
    input  logic [DATA_WIDTH-1:0]  rem_in,
    input  logic [DATA_WIDTH-1:0]  num_in,
    input  logic [DATA_WIDTH-1:0]  den_in,
    output udiv64_pkg::udiv_ctl_t  ctl_out,
    output logic [DATA_WIDTH-1:0]  rem_out,
    output logic [DATA_WIDTH-1:0]  num_out,
    output logic [DATA_WIDTH-1:0]  den_out
);
    import udiv64_pkg::*;

    logic                  top_bit;
    logic [DATA_WIDTH-1:0] shifted;
    logic [DATA_WIDTH+1:0] diff;
    logic                  fits;

    udiv_ctl_t             ctl_reg;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] num_reg;
    logic [DATA_WIDTH-1:0] den_reg;
    logic [DATA_WIDTH-1:0] rem_next;
    logic [DATA_WIDTH-1:0] num_next;

    // Shift in the next dividend bit, trial-subtract the divisor
    always_comb
    begin
        top_bit  = rem_in[DATA_WIDTH-1];
        shifted  = {rem_in[DATA_WIDTH-2:0], num_in[DATA_WIDTH-1]};
        diff     = {1'b0, top_bit, shifted} - {2'b00, den_in};
        fits     = ~diff[DATA_WIDTH+1];
        rem_next = fits ? diff[DATA_WIDTH-1:0] : shifted;
        // dividend bits leave at the top, quotient bits enter at the bottom
        num_next = {num_in[DATA_WIDTH-2:0], fits};
    end

    // Control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (advance)
        begin
            ctl_reg <= ctl_in;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_reg <= rem_next;
            num_reg <= num_next;
            den_reg <= den_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign num_out = num_reg;
    assign den_out = den_reg;

endmodule

// ----- rtl/core/unsigned_64bit_divider.sv -----
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Pipeline: DATA_WIDTH step stages followed by the output register.
// Throughput: one division per cycle; the whole pipeline holds while a result waits.
// Reset (rst_n, async, active low) clears all valid bits; data registers are not reset.
// Depends on udiv64_pkg and udiv64_step.
module unsigned_64bit_divider #(
    parameter int DATA_WIDTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  udiv64_pkg::field_t dividend,
    input  udiv64_pkg::field_t divisor,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output udiv64_pkg::field_t quotient,
    output udiv64_pkg::field_t remainder,
    output logic               div_by_zero
);
    import udiv64_pkg::*;

    udiv_ctl_t             ctl_s [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] rem_s [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] num_s [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] den_s [0:DATA_WIDTH];

    logic                  advance;
    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] quo_reg;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic                  dbz_reg;

    // Pipeline moves unless a finished result is held at the output
    assign advance   = ~out_valid_reg | rsp_ready;
    assign req_ready = advance;

    // Stage 0: operands masked to DATA_WIDTH, empty partial remainder
    assign num_s[0]       = dividend[DATA_WIDTH-1:0];
    assign den_s[0]       = divisor[DATA_WIDTH-1:0];
    assign rem_s[0]       = '0;
    assign ctl_s[0].valid = req_valid;
    assign ctl_s[0].dbz   = (divisor[DATA_WIDTH-1:0] == '0);

    // One step per quotient bit, most significant first
    for (genvar i = 0; i < DATA_WIDTH; i++)
    begin : g_step
        udiv64_step #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .ctl_in  (ctl_s[i]),
            .rem_in  (rem_s[i]),
            .num_in  (num_s[i]),
            .den_in  (den_s[i]),
            .ctl_out (ctl_s[i+1]),
            .rem_out (rem_s[i+1]),
            .num_out (num_s[i+1]),
            .den_out (den_s[i+1])
        );
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= ctl_s[DATA_WIDTH].valid;
        end
    end

    // Output data; zero divisor forces zero quotient and remainder
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            quo_reg <= ctl_s[DATA_WIDTH].dbz ? '0 : num_s[DATA_WIDTH];
            rem_reg <= ctl_s[DATA_WIDTH].dbz ? '0 : rem_s[DATA_WIDTH];
            dbz_reg <= ctl_s[DATA_WIDTH].dbz;
        end
    end

    assign rsp_valid   = out_valid_reg;
    assign quotient    = field_t'(quo_reg);
    assign remainder   = field_t'(rem_reg);
    assign div_by_zero = dbz_reg;

endmodule

// ----- tb/tb_unsigned_64bit_divider.sv -----
// Self-checking testbench for the pipelined unsigned 64-bit divider.
// Depends on udiv64_pkg and unsigned_64bit_divider; predicts quotient, remainder
// and the zero-divisor flag by bitwise long division and checks every output beat.
module tb_unsigned_64bit_divider;
    import udiv64_pkg::*;

    // One expected output beat
    typedef struct {
        field_t quo;
        field_t rem;
        logic   dbz;
    } division_answer_t;

    // Holds predicted answers in order and compares them with the output beats
    class division_scoreboard_t;
        division_answer_t expected_answers[$];
        int errors;
        int checked;
        int noted;
        int zero_divisors;

        function new();
            errors = 0;
            checked = 0;
            noted = 0;
            zero_divisors = 0;
        endfunction

        // Restoring division with a remainder one bit wider than the operands
        static function division_answer_t long_divide(field_t num, field_t den);
            division_answer_t ans;
            logic [FIELD_WIDTH:0] part;
            ans.quo = '0;
            ans.rem = '0;
            ans.dbz = 1'b0;
            if (den == '0)
            begin
                ans.dbz = 1'b1;
                return ans;
            end
            part = '0;
            for (int k = FIELD_WIDTH - 1; k >= 0; k--)
            begin
                part = {part[FIELD_WIDTH-1:0], num[k]};
                if (part >= {1'b0, den})
                begin
                    part = part - {1'b0, den};
                    ans.quo[k] = 1'b1;
                end
            end
            ans.rem = part[FIELD_WIDTH-1:0];
            return ans;
        endfunction

        function void note_request(field_t num, field_t den);
            expected_answers.push_back(long_divide(num, den));
            noted++;
            if (den == '0)
                zero_divisors++;
        endfunction

        function void check_result(field_t quo, field_t rem, logic dbz);
            division_answer_t want;
            if (expected_answers.size() == 0)
            begin
                $display("%0t: unexpected result beat quotient=%h remainder=%h div_by_zero=%b",
                         $time, quo, rem, dbz);
                errors++;
                return;
            end
            want = expected_answers.pop_front();
            checked++;
            if (quo !== want.quo)
            begin
                $display("%0t: quotient mismatch expected %h actual %h", $time, want.quo, quo);
                errors++;
            end
            if (rem !== want.rem)
            begin
                $display("%0t: remainder mismatch expected %h actual %h", $time, want.rem, rem);
                errors++;
            end
            if (dbz !== want.dbz)
            begin
                $display("%0t: div_by_zero mismatch expected %b actual %b", $time, want.dbz, dbz);
                errors++;
            end
        endfunction

        function int pending();
            return expected_answers.size();
        endfunction
    endclass

    localparam field_t ALL_ONES = '1;
    localparam field_t TOP_BIT  = field_t'(1) << (FIELD_WIDTH - 1);

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   req_valid = 1'b0;
    logic   req_ready;
    field_t dividend = '0;
    field_t divisor = '0;
    logic   rsp_valid;
    logic   rsp_ready = 1'b0;
    field_t quotient;
    field_t remainder;
    logic   div_by_zero;

    // Pacing: percent of cycles each side idles, plus a one-shot output hold-off
    int unsigned send_idle_pct = 27;
    int unsigned recv_idle_pct = 75;
    logic        hold_request = 1'b0;   // raised by the main sequence
    logic        hold_done = 1'b0;      // owned by the output side
    int          hold_left = 0;

    division_scoreboard_t sb = new();

    unsigned_64bit_divider uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .dividend   (dividend),
        .divisor    (divisor),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .quotient   (quotient),
        .remainder  (remainder),
        .div_by_zero(div_by_zero)
    );

    always #5 clk = ~clk;

    // Output side: random back-pressure, or a long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_request && !hold_done)
        begin
            hold_left = 200;
            hold_done <= 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Output monitor: values read here are the ones present before the edge
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_result(quotient, remainder, div_by_zero);
    end

    function automatic field_t rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Offer one division and return at the edge where the beat is taken
    task automatic send_div(input field_t num, input field_t den);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        dividend  <= num;
        divisor   <= den;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note_request(num, den);
    endtask

    // Random operands, shaped so small divisors, near-equal pairs and zero all occur
    task automatic send_random(input int count);
        field_t num;
        field_t den;
        int unsigned shape;
        repeat (count)
        begin
            num = rand64();
            den = rand64();
            shape = $urandom_range(99);
            if (shape < 4)
                den = '0;
            else if (shape < 40)
                den = den >> $urandom_range(FIELD_WIDTH - 1);
            else if (shape < 55)
            begin
                num = num >> $urandom_range(FIELD_WIDTH - 1);
                den = den >> $urandom_range(FIELD_WIDTH - 1);
            end
            else if (shape < 70)
                den = num - field_t'(3) + field_t'($urandom_range(6));
            send_div(num, den);
        end
    endtask

    task automatic send_directed();
        send_div('0, '0);
        send_div(ALL_ONES, '0);
        send_div('0, field_t'(1));
        send_div(ALL_ONES, field_t'(1));
        send_div(ALL_ONES, ALL_ONES);
        send_div(ALL_ONES - field_t'(1), ALL_ONES);
        send_div(ALL_ONES, ALL_ONES - field_t'(1));
        send_div(TOP_BIT, TOP_BIT);
        send_div(ALL_ONES, TOP_BIT);
        send_div(ALL_ONES, TOP_BIT + field_t'(1));
        send_div(TOP_BIT - field_t'(1), TOP_BIT);
        send_div(ALL_ONES, field_t'(2));
        send_div(ALL_ONES, field_t'(3));
        send_div(field_t'(12345), field_t'(7));
        send_div(field_t'(5), field_t'(5));
        send_div(field_t'(4), field_t'(9));
        send_div(field_t'(1), ALL_ONES);
        send_div(TOP_BIT, field_t'(1));
        send_div(field_t'(64'h5555_5555_5555_5555), field_t'(64'hAAAA_AAAA_AAAA_AAAA));
        send_div(field_t'(64'hAAAA_AAAA_AAAA_AAAA), field_t'(64'h5555_5555_5555_5555));
        send_div(field_t'(64'hFFFF_FFFF_0000_0000), field_t'(64'h0000_0000_FFFF_FFFF));
    endtask

    // Run limit
    initial
    begin
        #10_000_000;
        $display("tb_unsigned_64bit_divider: FAIL");
        $finish;
    end

    // Main sequence
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Slow output, mostly busy input
        send_directed();
        send_random(430);

        // Slow input, mostly ready output
        send_idle_pct = 75;
        recv_idle_pct = 27;
        send_random(430);

        // Full rate; start with a long output stall so the pipe fills up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request <= 1'b1;
        send_random(440);
        req_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        $display("Ran %0d divisions (%0d with a zero divisor); %0d output beats checked.",
                 sb.noted, sb.zero_divisors, sb.checked);
        $display("Pacing covered busy/idle on both sides, full rate, and a long output stall.");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_unsigned_64bit_divider: PASS");
        else
            $display("tb_unsigned_64bit_divider: FAIL");
        $finish;
    end

endmodule
